@@ sv/cmavg_pkg.sv @@
package cmavg_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int MAX_HALF_WIDTH = 7;
  localparam int DEPTH          = 2 * MAX_HALF_WIDTH + 1;
  localparam int HALF_W         = $clog2(MAX_HALF_WIDTH + 1);
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int SUM_W          = SAMPLE_WIDTH + CNT_W;
  localparam int MAG_W          = SUM_W - 1;
  localparam int GROUP_SIZE     = 4;
  localparam int GROUPS         = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PART_W         = SAMPLE_WIDTH + $clog2(GROUP_SIZE);
  localparam int PCNT_W         = $clog2(GROUP_SIZE + 1);
  localparam int RECIP_W        = 32;
  localparam int RECIP_SHIFT    = 31;
  localparam int PROD_W         = MAG_W + RECIP_W;
  localparam int FS_W           = 4;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int REG_IDX_W      = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_SIZE   = '0;
  localparam logic [FS_W-1:0]      FILTER_SIZE_RESET = 4'd3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_GATHER = 5'b00010,
    S_TOTAL  = 5'b00100,
    S_SCALE  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  // ceil(2^31 / c), exact truncating quotient for magnitudes below 2^27
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
    logic [RECIP_W-1:0] r;
    case (c)
      4'd1:    r = 32'd2147483648;
      4'd2:    r = 32'd1073741824;
      4'd3:    r = 32'd715827883;
      4'd4:    r = 32'd536870912;
      4'd5:    r = 32'd429496730;
      4'd6:    r = 32'd357913942;
      4'd7:    r = 32'd306783379;
      4'd8:    r = 32'd268435456;
      4'd9:    r = 32'd238609295;
      4'd10:   r = 32'd214748365;
      4'd11:   r = 32'd195225787;
      4'd12:   r = 32'd178956971;
      4'd13:   r = 32'd165191050;
      4'd14:   r = 32'd153391690;
      4'd15:   r = 32'd143165577;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/cmavg_in_if.sv @@
interface cmavg_in_if;
  logic                 valid;
  logic                 ready;
  cmavg_pkg::sample_t   sample;
  logic                 frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink (input valid, input sample, input frame_end, output ready);
endinterface

@@ sv/cmavg_out_if.sv @@
interface cmavg_out_if;
  logic                        valid;
  logic                        ready;
  cmavg_pkg::sample_t          average;
  logic [cmavg_pkg::CNT_W-1:0] used_count;
  logic                        frame_last;

  modport source (output valid, output average, output used_count, output frame_last,
                  input ready);
  modport sink (input valid, input average, input used_count, input frame_last,
                output ready);
endinterface

@@ sv/centered_moving_average_skip_zero.sv @@
// a result passes the gather, total, scale and emit states after the edge that accepts its item
// an item without a result leaves the block idle; an item with a result holds input off until emitted
// a frame_end item flushes one result per buffered center, at most 8 results, before input resumes
// each result runs the cell row, the two-level adder tree and the reciprocal multiplier
// reset is synchronous: store, counters and output clear, filter_size returns to 3
module centered_moving_average_skip_zero (
  input  logic                           clk,
  input  logic                           rst,
  cmavg_in_if.sink                       feed,
  cmavg_out_if.source                    results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cmavg_pkg::ADDR_W-1:0]   paddr,
  input  logic [cmavg_pkg::DATA_W-1:0]   pwdata,
  output logic [cmavg_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int PW = cmavg_pkg::IDX_W + 1;

  cmavg_pkg::state_t                    state;
  logic [cmavg_pkg::FS_W-1:0]           filter_size;
  logic [cmavg_pkg::HALF_W-1:0]         seen;
  logic [cmavg_pkg::HALF_W-1:0]         center;
  logic                                 flushing;
  logic                                 out_valid;
  cmavg_pkg::sample_t                   out_average;
  logic [cmavg_pkg::CNT_W-1:0]          out_count;
  logic                                 out_last;

  logic [cmavg_pkg::HALF_W-1:0]         half_c;
  logic [cmavg_pkg::HALF_W-1:0]         seen_c;
  logic [cmavg_pkg::HALF_W:0]           seen_inc;
  logic                                 accept;
  logic                                 out_free;
  logic                                 cfg_we;
  logic                                 flush_done;
  cmavg_pkg::cell_ctl_t                 ctl;

  cmavg_pkg::sample_t                   cell_value [cmavg_pkg::DEPTH];
  cmavg_pkg::sample_t                   cell_term  [cmavg_pkg::DEPTH];
  logic [cmavg_pkg::DEPTH-1:0]          cell_hit;
  logic [cmavg_pkg::DEPTH-1:0]          pick;

  logic signed [cmavg_pkg::SUM_W-1:0]   total;
  logic [cmavg_pkg::CNT_W-1:0]          count;
  logic [cmavg_pkg::MAG_W-1:0]          mag_c;
  logic [cmavg_pkg::PROD_W-1:0]         prod;
  logic                                 prod_neg;
  logic [cmavg_pkg::CNT_W-1:0]          prod_count;
  logic [cmavg_pkg::SAMPLE_WIDTH-1:0]   quot_c;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite
                  && (paddr[cmavg_pkg::ADDR_W-1:2] == cmavg_pkg::REG_FILTER_SIZE);
  assign prdata = (paddr[cmavg_pkg::ADDR_W-1:2] == cmavg_pkg::REG_FILTER_SIZE)
                  ? cmavg_pkg::DATA_W'(filter_size) : '0;

  always_comb begin
    if (filter_size[cmavg_pkg::FS_W-1:1] > cmavg_pkg::HALF_W'(cmavg_pkg::MAX_HALF_WIDTH)) begin
      half_c = cmavg_pkg::HALF_W'(cmavg_pkg::MAX_HALF_WIDTH);
    end else begin
      half_c = cmavg_pkg::HALF_W'(filter_size[cmavg_pkg::FS_W-1:1]);
    end
  end

  assign seen_c   = (seen > half_c) ? half_c : seen;
  assign seen_inc = {1'b0, seen_c} + 1'b1;

  assign feed.ready = (state == cmavg_pkg::S_IDLE);
  assign accept     = feed.valid && feed.ready;
  assign out_free   = !out_valid || results.ready;
  assign flush_done = (state == cmavg_pkg::S_EMIT) && out_free && flushing
                      && (center == '0);

  assign ctl = '{shift: accept, clear: flush_done};

  // window of cells around the current center
  for (genvar i = 0; i < cmavg_pkg::DEPTH; i++) begin : g_cell
    assign pick[i] = (PW'(i) + PW'(half_c) >= PW'(center))
                     && (PW'(i) <= PW'(center) + PW'(half_c));
    if (i == 0) begin : g_head
      cmavg_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .pick     (pick[i]),
        .shift_in (feed.sample),
        .value    (cell_value[i]),
        .term     (cell_term[i]),
        .hit      (cell_hit[i])
      );
    end else begin : g_body
      cmavg_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .pick     (pick[i]),
        .shift_in (cell_value[i-1]),
        .value    (cell_value[i]),
        .term     (cell_term[i]),
        .hit      (cell_hit[i])
      );
    end
  end

  cmavg_sum u_sum (
    .clk   (clk),
    .term  (cell_term),
    .hit   (cell_hit),
    .total (total),
    .count (count)
  );

  // divide by count: magnitude times reciprocal, then restore the sign
  assign mag_c  = total[cmavg_pkg::SUM_W-1] ? cmavg_pkg::MAG_W'(-total)
                                            : cmavg_pkg::MAG_W'(total);
  assign quot_c = prod[cmavg_pkg::RECIP_SHIFT +: cmavg_pkg::SAMPLE_WIDTH];

  always_ff @(posedge clk) begin
    if (state == cmavg_pkg::S_SCALE) begin
      prod       <= cmavg_pkg::PROD_W'(mag_c) * cmavg_pkg::PROD_W'(cmavg_pkg::recip(count));
      prod_neg   <= total[cmavg_pkg::SUM_W-1];
      prod_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cmavg_pkg::S_IDLE;
      filter_size <= cmavg_pkg::FILTER_SIZE_RESET;
      seen        <= '0;
      center      <= '0;
      flushing    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        filter_size <= pwdata[cmavg_pkg::FS_W-1:0];
      end
      if (out_valid && results.ready && (state != cmavg_pkg::S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        cmavg_pkg::S_IDLE: begin
          if (accept) begin
            if (feed.frame_end) begin
              flushing <= 1'b1;
              center   <= seen_c;
              state    <= cmavg_pkg::S_GATHER;
            end else begin
              flushing <= 1'b0;
              seen     <= (seen_inc > {1'b0, half_c}) ? half_c
                                                      : seen_inc[cmavg_pkg::HALF_W-1:0];
              if (seen_c >= half_c) begin
                center <= half_c;
                state  <= cmavg_pkg::S_GATHER;
              end
            end
          end
        end
        cmavg_pkg::S_GATHER: state <= cmavg_pkg::S_TOTAL;
        cmavg_pkg::S_TOTAL:  state <= cmavg_pkg::S_SCALE;
        cmavg_pkg::S_SCALE:  state <= cmavg_pkg::S_EMIT;
        cmavg_pkg::S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (flushing && (center != '0)) begin
              center <= center - 1'b1;
              state  <= cmavg_pkg::S_GATHER;
            end else begin
              if (flushing) begin
                seen <= '0;
              end
              flushing <= 1'b0;
              state    <= cmavg_pkg::S_IDLE;
            end
          end
        end
        default: state <= cmavg_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == cmavg_pkg::S_EMIT) && out_free) begin
      out_average <= prod_neg ? -quot_c : quot_c;
      out_count   <= prod_count;
      out_last    <= flushing && (center == '0);
    end
  end

  assign results.valid      = out_valid;
  assign results.average    = out_average;
  assign results.used_count = out_count;
  assign results.frame_last = out_last;

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !$past(results.valid)) |-> $past(state == cmavg_pkg::S_EMIT))
    else $error("result appeared outside the emit step");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.used_count == '0)) |-> (results.average == '0))
    else $error("empty window gave a nonzero average");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    flush_done |=> ((seen == '0) && (state == cmavg_pkg::S_IDLE) && (cell_hit == '0)))
    else $error("frame flush did not clear the window");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |=> (results.valid && $stable(results.average)
                                           && $stable(results.used_count)
                                           && $stable(results.frame_last)))
    else $error("result item changed while stalled");

endmodule

@@ sv/cmavg_cell.sv @@
module cmavg_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  cmavg_pkg::cell_ctl_t ctl,
  input  logic                 pick,
  input  cmavg_pkg::sample_t   shift_in,
  output cmavg_pkg::sample_t   value,
  output cmavg_pkg::sample_t   term,
  output logic                 hit
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      value <= '0;
    end else if (ctl.shift) begin
      value <= shift_in;
    end
  end

  assign hit  = pick && (value != '0);
  assign term = hit ? value : '0;

endmodule

@@ sv/cmavg_sum.sv @@
module cmavg_sum (
  input  logic                                clk,
  input  cmavg_pkg::sample_t                  term [cmavg_pkg::DEPTH],
  input  logic [cmavg_pkg::DEPTH-1:0]         hit,
  output logic signed [cmavg_pkg::SUM_W-1:0]  total,
  output logic [cmavg_pkg::CNT_W-1:0]         count
);

  logic signed [cmavg_pkg::PART_W-1:0] part_c [cmavg_pkg::GROUPS];
  logic [cmavg_pkg::PCNT_W-1:0]        pcnt_c [cmavg_pkg::GROUPS];
  logic signed [cmavg_pkg::PART_W-1:0] part   [cmavg_pkg::GROUPS];
  logic [cmavg_pkg::PCNT_W-1:0]        pcnt   [cmavg_pkg::GROUPS];
  logic signed [cmavg_pkg::SUM_W-1:0]  total_c;
  logic [cmavg_pkg::CNT_W-1:0]         count_c;

  // first level: one partial sum per group of cells
  always_comb begin
    for (int g = 0; g < cmavg_pkg::GROUPS; g++) begin
      part_c[g] = '0;
      pcnt_c[g] = '0;
    end
    for (int i = 0; i < cmavg_pkg::DEPTH; i++) begin
      part_c[i / cmavg_pkg::GROUP_SIZE] = part_c[i / cmavg_pkg::GROUP_SIZE]
                                          + cmavg_pkg::PART_W'(term[i]);
      pcnt_c[i / cmavg_pkg::GROUP_SIZE] = pcnt_c[i / cmavg_pkg::GROUP_SIZE]
                                          + cmavg_pkg::PCNT_W'(hit[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < cmavg_pkg::GROUPS; g++) begin
      part[g] <= part_c[g];
      pcnt[g] <= pcnt_c[g];
    end
  end

  // second level: combine the groups
  always_comb begin
    total_c = '0;
    count_c = '0;
    for (int g = 0; g < cmavg_pkg::GROUPS; g++) begin
      total_c = total_c + cmavg_pkg::SUM_W'(part[g]);
      count_c = count_c + cmavg_pkg::CNT_W'(pcnt[g]);
    end
  end

  always_ff @(posedge clk) begin
    total <= total_c;
    count <= count_c;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 12;
  localparam int N_RANDOM = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int N_DIR = 22;

  typedef struct packed {
    cmavg_pkg::sample_t          average;
    logic [cmavg_pkg::CNT_W-1:0] used_count;
    logic                        frame_last;
  } avg_result_t;

  typedef struct packed {
    logic [cmavg_pkg::FS_W-1:0]  size;
    cmavg_pkg::sample_t          sample;
    logic                        fend;
    logic                        typed;
    cmavg_pkg::sample_t          avg;
    logic [cmavg_pkg::CNT_W-1:0] cnt;
    logic                        last_out;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  cmavg_in_if  feed_if ();
  cmavg_out_if res_if ();

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [cmavg_pkg::ADDR_W-1:0] paddr;
  logic [cmavg_pkg::DATA_W-1:0] pwdata;
  logic [cmavg_pkg::DATA_W-1:0] prdata;
  logic                         pready;

  centered_moving_average_skip_zero uut (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // predictor state
  cmavg_pkg::sample_t         hist [cmavg_pkg::DEPTH];
  int                         run_len;
  logic [cmavg_pkg::FS_W-1:0] size_reg;
  avg_result_t                expected_avgs [$];

  int  errors;
  int  items_sent;
  int  frames_done;
  int  results_seen;
  int  size_writes;
  int  idle_cycles;
  bit  feed_burst;
  bit  drain_burst;

  dir_row_t dir_rows [N_DIR] = '{
    '{4'd0,  24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF, 4'd1, 1'b0},
    '{4'd0,  24'h800000, 1'b0, 1'b1, 24'h800000, 4'd1, 1'b0},
    '{4'd0,  24'h000000, 1'b0, 1'b1, 24'h000000, 4'd0, 1'b0},
    '{4'd0,  24'h000001, 1'b1, 1'b1, 24'h000001, 4'd1, 1'b1},
    '{4'd3,  24'h000100, 1'b1, 1'b1, 24'h000100, 4'd1, 1'b1},
    '{4'd3,  24'h7FFFFF, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd3,  24'h7FFFFF, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd3,  24'h800000, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd3,  24'h000000, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd3,  24'h000123, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd3,  24'hFFFFFB, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd14, 24'h000400, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd14, 24'h800000, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd14, 24'h000000, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd14, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd14, 24'h0055AA, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd1,  24'hABCDEF, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd1,  24'hFFFFFF, 1'b1, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd15, 24'h800000, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd15, 24'h800000, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd15, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 4'd0, 1'b0},
    '{4'd15, 24'h000000, 1'b1, 1'b0, 24'h0, 4'd0, 1'b0}
  };

  function automatic void average_window(int center, int half, logic fl);
    longint      total;
    int          n;
    avg_result_t r;
    total = 0;
    n = 0;
    for (int k = center - half; k <= center + half; k++) begin
      if (k >= 0 && k < cmavg_pkg::DEPTH && hist[k] != 0) begin
        total += hist[k];
        n++;
      end
    end
    r.average    = (n > 0) ? cmavg_pkg::sample_t'(total / n) : '0;
    r.used_count = (n > 15) ? cmavg_pkg::CNT_W'(15) : cmavg_pkg::CNT_W'(n);
    r.frame_last = fl;
    expected_avgs.push_back(r);
  endfunction

  function automatic void predict_smoothing(cmavg_pkg::sample_t s, logic fend);
    int half;
    int lag;
    half = size_reg >> 1;
    if (half > cmavg_pkg::MAX_HALF_WIDTH) half = cmavg_pkg::MAX_HALF_WIDTH;
    lag = (run_len > half) ? half : run_len;
    for (int k = cmavg_pkg::DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = s;
    if (!fend) begin
      if (lag >= half) average_window(half, half, 1'b0);
      run_len = (lag + 1 > half) ? half : lag + 1;
    end else begin
      for (int k = lag; k >= 0; k--) average_window(k, half, k == 0);
      for (int k = 0; k < cmavg_pkg::DEPTH; k++) hist[k] = '0;
      run_len = 0;
    end
  endfunction

  function automatic cmavg_pkg::sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;
    if (pick < 20) return 24'h7FFFFF;
    if (pick < 25) return 24'h800000;
    if (pick < 50) return cmavg_pkg::sample_t'(int'($urandom_range(0, 2046)) - 1023);
    return cmavg_pkg::sample_t'($urandom);
  endfunction

  task automatic send_item(cmavg_pkg::sample_t s, logic fend);
    int gap;
    if ($urandom_range(0, 29) == 0) feed_burst = !feed_burst;
    gap = feed_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      feed_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed_if.valid     <= 1'b1;
    feed_if.sample    <= s;
    feed_if.frame_end <= fend;
    do @(posedge clk); while (!feed_if.ready);
    predict_smoothing(s, fend);
    items_sent++;
    if (fend) frames_done++;
  endtask

  // hold input until every pending result is out, then let the block go quiet
  task automatic settle();
    feed_if.valid <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [cmavg_pkg::FS_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {cmavg_pkg::REG_FILTER_SIZE, 2'b00};
    pwdata  <= cmavg_pkg::DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_reg = v;
    size_writes++;
    @(posedge clk);
    if (prdata !== cmavg_pkg::DATA_W'(v)) begin
      $error("filter_size: expected %0d, got %0d", v, prdata);
      errors++;
    end
    if (pready !== 1'b1) begin
      $error("pready: expected 1, got %0b", pready);
      errors++;
    end
  endtask

  initial begin : stimulus
    dir_row_t                   row;
    avg_result_t                typed_res;
    logic [cmavg_pkg::FS_W-1:0] sz;
    int                         nframes;
    int                         len;
    bit                         open_frame;
    rst               <= 1'b1;
    feed_if.valid     <= 1'b0;
    feed_if.sample    <= '0;
    feed_if.frame_end <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    errors = 0;
    items_sent = 0;
    frames_done = 0;
    size_writes = 0;
    feed_burst = 0;
    size_reg = cmavg_pkg::FILTER_SIZE_RESET;
    run_len = 0;
    for (int k = 0; k < cmavg_pkg::DEPTH; k++) hist[k] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      row = dir_rows[i];
      if (row.size != size_reg) begin
        settle();
        write_size(row.size);
      end
      send_item(row.sample, row.fend);
      if (row.typed) begin
        typed_res = '{row.avg, row.cnt, row.last_out};
        void'(expected_avgs.pop_back());
        expected_avgs.push_back(typed_res);
      end
    end

    while (items_sent < N_DIR + N_RANDOM) begin
      sz = $urandom_range(0, 15);
      settle();
      write_size(sz);
      nframes = $urandom_range(1, 4);
      for (int f = 0; f < nframes; f++) begin
        len = $urandom_range(1, 20);
        // sometimes leave the frame open so the next size lands mid-frame
        open_frame = (f == nframes - 1) && ($urandom_range(0, 4) == 0);
        for (int j = 0; j < len; j++)
          send_item(rand_sample(), (j == len - 1) && !open_frame);
      end
    end

    feed_if.valid <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items in %0d frames, %0d results checked", items_sent,
             frames_done, results_seen);
    $display("filter size written %0d times, 0 and 15 included", size_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : collect_results
    int          stall;
    avg_result_t want;
    res_if.ready <= 1'b0;
    results_seen = 0;
    drain_burst = 0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 29) == 0) drain_burst = !drain_burst;
      stall = drain_burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      results_seen++;
      if (expected_avgs.size() == 0) begin
        $error("unexpected item: average %0d used_count %0d frame_last %0d",
               res_if.average, res_if.used_count, res_if.frame_last);
        errors++;
      end else begin
        want = expected_avgs.pop_front();
        if (res_if.average !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, res_if.average);
          errors++;
        end
        if (res_if.used_count !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count, res_if.used_count);
          errors++;
        end
        if (res_if.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last, res_if.frame_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((feed_if.valid && feed_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
sv/cmavg_pkg.sv
sv/cmavg_in_if.sv
sv/cmavg_out_if.sv
sv/cmavg_cell.sv
sv/cmavg_sum.sv
sv/centered_moving_average_skip_zero.sv
dv/tb_top.sv
